### rtl/ptst_pkg.sv
// ----------------------------------------------------------------------------
// ptst_pkg
// Shared types and constants for the page table state tracker.
// ----------------------------------------------------------------------------
package ptst_pkg;

    localparam int PAGE_W    = 10;
    localparam int FRAME_W   = 8;
    localparam int CNT_W     = PAGE_W + 1;
    localparam int NUM_PAGES = 1 << PAGE_W;

    localparam logic [CNT_W-1:0] PAGE_LIMIT = CNT_W'(NUM_PAGES);

    typedef enum logic [2:0] {
        OP_ALLOC  = 3'd0,
        OP_FREE   = 3'd1,
        OP_QUERY  = 3'd2,
        OP_LOAD   = 3'd3,
        OP_RESID  = 3'd4,
        OP_NONRES = 3'd5,
        OP_EVICT  = 3'd6
    } t_op;

    typedef enum logic [2:0] {
        PS_UNUSED   = 3'd0,
        PS_NONRES   = 3'd1,
        PS_LOADING  = 3'd2,
        PS_RESIDENT = 3'd3,
        PS_EVICTING = 3'd4
    } t_pstate;

    typedef enum logic [2:0] {
        STS_OK        = 3'd0,
        STS_INVALID   = 3'd1,
        STS_UNUSED    = 3'd2,
        STS_STATE     = 3'd3,
        STS_FRAME     = 3'd4,
        STS_EXHAUSTED = 3'd5
    } t_status;

    // classified operation handed from front to back
    typedef struct packed {
        t_op                op;
        logic [PAGE_W-1:0]  page_id;
        logic [FRAME_W-1:0] frame_num;
        logic               invalid;
    } t_cmd;

endpackage

### rtl/ptst_front.sv
// ----------------------------------------------------------------------------
// ptst_front
// Holds max_pages, accepts operations and classifies them for the back end.
// ----------------------------------------------------------------------------
module ptst_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [2:0]                     i_operation,
    input  logic [ptst_pkg::PAGE_W-1:0]    i_page_id,
    input  logic [ptst_pkg::FRAME_W-1:0]   i_frame_num,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [ptst_pkg::CNT_W-1:0]     i_cfg_max_pages,
    input  logic                           i_q_full,
    output logic                           o_push,
    output ptst_pkg::t_cmd                 o_cmd,
    output logic [ptst_pkg::CNT_W-1:0]     o_limit
);

    logic [ptst_pkg::CNT_W-1:0] r_max_pages;
    ptst_pkg::t_op              op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_pages <= ptst_pkg::PAGE_LIMIT;
        end else if (i_cfg_valid) begin
            r_max_pages <= i_cfg_max_pages;
        end
    end

    assign o_cfg_ready = 1'b1;

    // values above the table size act as the table size
    assign o_limit = (r_max_pages > ptst_pkg::PAGE_LIMIT) ? ptst_pkg::PAGE_LIMIT
                                                          : r_max_pages;

    // the unassigned code behaves as query
    always_comb begin
        case (ptst_pkg::t_op'(i_operation))
            ptst_pkg::OP_ALLOC:  op = ptst_pkg::OP_ALLOC;
            ptst_pkg::OP_FREE:   op = ptst_pkg::OP_FREE;
            ptst_pkg::OP_LOAD:   op = ptst_pkg::OP_LOAD;
            ptst_pkg::OP_RESID:  op = ptst_pkg::OP_RESID;
            ptst_pkg::OP_NONRES: op = ptst_pkg::OP_NONRES;
            ptst_pkg::OP_EVICT:  op = ptst_pkg::OP_EVICT;
            default:             op = ptst_pkg::OP_QUERY;
        endcase
    end

    assign o_cmd.op        = op;
    assign o_cmd.page_id   = i_page_id;
    assign o_cmd.frame_num = i_frame_num;
    assign o_cmd.invalid   = ({1'b0, i_page_id} >= o_limit);

    assign o_stall = i_q_full;
    assign o_push  = i_valid && !i_q_full;

endmodule

### rtl/ptst_queue.sv
// ----------------------------------------------------------------------------
// ptst_queue
// Two-entry queue of classified operations between front and back.
// ----------------------------------------------------------------------------
module ptst_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ptst_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output ptst_pkg::t_cmd o_cmd
);

    ptst_pkg::t_cmd r_slot [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_count;
    logic [1:0]     n_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_cmd   = r_slot[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !(i_pop && o_valid)) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop && o_valid) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop && o_valid) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

### rtl/ptst_back.sv
// ----------------------------------------------------------------------------
// ptst_back
// Executes operations: registered table reads, checked update, result register.
// ----------------------------------------------------------------------------
module ptst_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [ptst_pkg::CNT_W-1:0]     i_limit,
    input  logic                           i_q_valid,
    input  ptst_pkg::t_cmd                 i_q_cmd,
    output logic                           o_q_pop,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [2:0]                     o_status,
    output logic [ptst_pkg::PAGE_W-1:0]    o_result_page,
    output logic [2:0]                     o_page_state,
    output logic                           o_frame_valid,
    output logic [ptst_pkg::FRAME_W-1:0]   o_frame_out,
    output logic [ptst_pkg::CNT_W-1:0]     o_pages_in_use
);

    typedef enum logic [1:0] {
        B_IDLE = 2'b01,
        B_EXEC = 2'b10
    } t_bstate;

    localparam int PW = ptst_pkg::PAGE_W;
    localparam int FW = ptst_pkg::FRAME_W;
    localparam int CW = ptst_pkg::CNT_W;

    // tables
    ptst_pkg::t_pstate state_mem [ptst_pkg::NUM_PAGES];
    logic [FW-1:0]     frame_mem [ptst_pkg::NUM_PAGES];
    logic [PW-1:0]     stack_mem [ptst_pkg::NUM_PAGES];

    t_bstate           r_bstate;
    ptst_pkg::t_cmd    r_cmd;
    ptst_pkg::t_pstate r_rd_state;
    logic [FW-1:0]     r_rd_frame;
    logic [PW-1:0]     r_rd_stack;

    logic [CW-1:0]     r_free_depth, n_free_depth;
    logic [CW-1:0]     r_fresh_next, n_fresh_next;
    logic [CW-1:0]     r_in_use,     n_in_use;

    logic              r_out_valid;
    ptst_pkg::t_status r_status;
    logic [PW-1:0]     r_page;
    logic [2:0]        r_pstate;
    logic              r_fvalid;
    logic [FW-1:0]     r_frame;

    logic              pop;
    logic              exec_go;
    ptst_pkg::t_pstate cur_state;
    ptst_pkg::t_pstate new_state;
    logic [FW-1:0]     new_frame;
    ptst_pkg::t_status status;
    logic [PW-1:0]     page;
    logic              have_page;
    logic              state_we;
    logic [PW-1:0]     state_wa;
    ptst_pkg::t_pstate state_wd;
    logic              frame_we;
    logic              stack_we;
    logic              fv;

    assign pop     = (r_bstate == B_IDLE) && i_q_valid;
    assign o_q_pop = pop;
    assign exec_go = (r_bstate == B_EXEC) && (!r_out_valid || !i_stall);

    // entries at or above the fresh-id mark were never allocated: unused
    assign cur_state = ({1'b0, r_cmd.page_id} < r_fresh_next) ? r_rd_state
                                                              : ptst_pkg::PS_UNUSED;

    always_comb begin
        n_free_depth = r_free_depth;
        n_fresh_next = r_fresh_next;
        n_in_use     = r_in_use;
        status       = ptst_pkg::STS_OK;
        page         = r_cmd.page_id;
        have_page    = 1'b1;
        new_state    = cur_state;
        new_frame    = r_rd_frame;
        state_we     = 1'b0;
        state_wa     = r_cmd.page_id;
        state_wd     = ptst_pkg::PS_UNUSED;
        frame_we     = 1'b0;
        stack_we     = 1'b0;

        if (r_cmd.op == ptst_pkg::OP_ALLOC) begin
            if (r_free_depth != '0) begin
                page         = r_rd_stack;
                n_free_depth = r_free_depth - CW'(1);
            end else if (r_fresh_next < i_limit) begin
                page         = r_fresh_next[PW-1:0];
                n_fresh_next = r_fresh_next + CW'(1);
            end else begin
                status    = ptst_pkg::STS_EXHAUSTED;
                page      = '0;
                have_page = 1'b0;
            end
            if (status == ptst_pkg::STS_OK) begin
                state_we  = 1'b1;
                state_wa  = page;
                state_wd  = ptst_pkg::PS_NONRES;
                new_state = ptst_pkg::PS_NONRES;
                n_in_use  = r_in_use + CW'(1);
            end
        end else if (r_cmd.invalid) begin
            status    = ptst_pkg::STS_INVALID;
            have_page = 1'b0;
        end else if (cur_state == ptst_pkg::PS_UNUSED) begin
            status = ptst_pkg::STS_UNUSED;
        end else begin
            case (r_cmd.op)
                ptst_pkg::OP_FREE: begin
                    if (cur_state != ptst_pkg::PS_NONRES ||
                        r_free_depth >= ptst_pkg::PAGE_LIMIT) begin
                        status = ptst_pkg::STS_STATE;
                    end else begin
                        new_state    = ptst_pkg::PS_UNUSED;
                        stack_we     = 1'b1;
                        n_free_depth = r_free_depth + CW'(1);
                        if (r_in_use != '0) begin
                            n_in_use = r_in_use - CW'(1);
                        end
                    end
                end
                ptst_pkg::OP_LOAD: begin
                    if (cur_state != ptst_pkg::PS_NONRES) begin
                        status = ptst_pkg::STS_STATE;
                    end else begin
                        new_state = ptst_pkg::PS_LOADING;
                        new_frame = r_cmd.frame_num;
                        frame_we  = 1'b1;
                    end
                end
                ptst_pkg::OP_RESID: begin
                    if (cur_state == ptst_pkg::PS_RESIDENT ||
                        cur_state == ptst_pkg::PS_EVICTING) begin
                        status = ptst_pkg::STS_STATE;
                    end else if (cur_state == ptst_pkg::PS_LOADING &&
                                 r_rd_frame != r_cmd.frame_num) begin
                        status = ptst_pkg::STS_FRAME;
                    end else begin
                        new_state = ptst_pkg::PS_RESIDENT;
                        new_frame = r_cmd.frame_num;
                        frame_we  = 1'b1;
                    end
                end
                ptst_pkg::OP_NONRES: begin
                    new_state = ptst_pkg::PS_NONRES;
                end
                ptst_pkg::OP_EVICT: begin
                    if (cur_state != ptst_pkg::PS_RESIDENT) begin
                        status = ptst_pkg::STS_STATE;
                    end else begin
                        new_state = ptst_pkg::PS_EVICTING;
                    end
                end
                default: begin
                end
            endcase
            if (status == ptst_pkg::STS_OK && new_state != cur_state) begin
                state_we = 1'b1;
                state_wd = new_state;
            end
        end

        if (!have_page) begin
            new_state = ptst_pkg::PS_UNUSED;
        end
    end

    assign fv = (new_state == ptst_pkg::PS_LOADING)  ||
                (new_state == ptst_pkg::PS_RESIDENT) ||
                (new_state == ptst_pkg::PS_EVICTING);

    // table ports
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_rd_state <= state_mem[i_q_cmd.page_id];
            r_rd_frame <= frame_mem[i_q_cmd.page_id];
            r_rd_stack <= stack_mem[r_free_depth[PW-1:0] - PW'(1)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec_go && state_we) begin
            state_mem[state_wa] <= state_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec_go && frame_we) begin
            frame_mem[r_cmd.page_id] <= r_cmd.frame_num;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec_go && stack_we) begin
            stack_mem[r_free_depth[PW-1:0]] <= r_cmd.page_id;
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bstate     <= B_IDLE;
            r_free_depth <= '0;
            r_fresh_next <= '0;
            r_in_use     <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            case (r_bstate)
                B_IDLE: begin
                    if (pop) begin
                        r_bstate <= B_EXEC;
                    end
                end
                B_EXEC: begin
                    if (exec_go) begin
                        r_bstate <= B_IDLE;
                    end
                end
                default: r_bstate <= B_IDLE;
            endcase
            if (exec_go) begin
                r_free_depth <= n_free_depth;
                r_fresh_next <= n_fresh_next;
                r_in_use     <= n_in_use;
                r_out_valid  <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_cmd <= i_q_cmd;
        end
        if (exec_go) begin
            r_status <= status;
            r_page   <= page;
            r_pstate <= new_state;
            r_fvalid <= fv;
            r_frame  <= fv ? new_frame : '0;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_status;
    assign o_result_page  = r_page;
    assign o_page_state   = r_pstate;
    assign o_frame_valid  = r_fvalid;
    assign o_frame_out    = r_frame;
    assign o_pages_in_use = r_in_use;

endmodule

### rtl/page_table_state_tracker_core.sv
// ----------------------------------------------------------------------------
// page_table_state_tracker_core
// Per-page lifecycle state and frame tracking with checked transitions and
// a LIFO recycle stack for freed page ids.
// ----------------------------------------------------------------------------
//
// channel   direction  handshake              payload
// --------  ---------  ---------------------  --------------------------------
// in        sink       i_valid / o_stall      operation, page_id, frame_num
// out       source     o_valid / i_stall      status, result_page, page_state,
//                                             frame_valid, frame_out,
//                                             pages_in_use
// cfg       sink       i_cfg_valid / o_cfg_ready  max_pages
//
// Each operation passes through the back end in order: first the registered
// read of the state, frame and stack tables, then the checked update and
// result register. The back end takes no new operation until the current
// result is registered, and a stalled result holds it in the update step.
// Reset is synchronous; no clearing pass: table entries at or above the fresh
// id counter read as unused, the other tables are read only once written.
// The two-entry queue lets input keep flowing while a result is stalled.
//
module page_table_state_tracker_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // operation in
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [2:0]                     i_operation,
    input  logic [ptst_pkg::PAGE_W-1:0]    i_page_id,
    input  logic [ptst_pkg::FRAME_W-1:0]   i_frame_num,
    // result out
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [2:0]                     o_status,
    output logic [ptst_pkg::PAGE_W-1:0]    o_result_page,
    output logic [2:0]                     o_page_state,
    output logic                           o_frame_valid,
    output logic [ptst_pkg::FRAME_W-1:0]   o_frame_out,
    output logic [ptst_pkg::CNT_W-1:0]     o_pages_in_use,
    // max_pages write
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [ptst_pkg::CNT_W-1:0]     i_cfg_max_pages
);

    logic                       q_full;
    logic                       push;
    ptst_pkg::t_cmd             push_cmd;
    logic [ptst_pkg::CNT_W-1:0] limit;
    logic                       q_valid;
    logic                       q_pop;
    ptst_pkg::t_cmd             q_cmd;

    // front: config register, op decode, id range check
    ptst_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_operation     (i_operation),
        .i_page_id       (i_page_id),
        .i_frame_num     (i_frame_num),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_max_pages (i_cfg_max_pages),
        .i_q_full        (q_full),
        .o_push          (push),
        .o_cmd           (push_cmd),
        .o_limit         (limit)
    );

    // decoupling queue
    ptst_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    // back: tables, id allocator, result register
    ptst_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_limit        (limit),
        .i_q_valid      (q_valid),
        .i_q_cmd        (q_cmd),
        .o_q_pop        (q_pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_result_page  (o_result_page),
        .o_page_state   (o_page_state),
        .o_frame_valid  (o_frame_valid),
        .o_frame_out    (o_frame_out),
        .o_pages_in_use (o_pages_in_use)
    );

endmodule
